// ===== rtl/lss_pkg.sv =====
`timescale 1ns / 1ps

package lss_pkg;

    // Pixel store geometry
    localparam int MAX_PIXELS = 512;
    localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int WORD_W     = 24;

    // Command codes
    localparam logic [2:0] CMD_SET   = 3'd0;
    localparam logic [2:0] CMD_FILL  = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_SHOW  = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    // Line phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_GAP  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_LED_COUNT  = 3'd0;
    localparam logic [2:0] CFG_ZERO_HIGH  = 3'd1;
    localparam logic [2:0] CFG_ZERO_LOW   = 3'd2;
    localparam logic [2:0] CFG_ONE_HIGH   = 3'd3;
    localparam logic [2:0] CFG_ONE_LOW    = 3'd4;
    localparam logic [2:0] CFG_LATCH_GAP  = 3'd5;

    // Configuration reset values
    localparam logic [9:0]  RST_LED_COUNT = 10'd0;
    localparam logic [7:0]  RST_ZERO_HIGH = 8'd4;
    localparam logic [7:0]  RST_ZERO_LOW  = 8'd9;
    localparam logic [7:0]  RST_ONE_HIGH  = 8'd8;
    localparam logic [7:0]  RST_ONE_LOW   = 8'd5;
    localparam logic [15:0] RST_LATCH_GAP = 16'd600;

    // Controller to datapath
    typedef struct packed {
        logic       in_load;     // capture the accepted transaction
        logic       tick_exec;   // run one bit clock tick
        logic       show_start;  // start a frame at pixel zero
        logic       load_word;   // load the fetched pixel word and go high
        logic       wr_set;      // write one scaled pixel
        logic       wr_sweep;    // write the sweep address and advance it
        logic       sweep_zero;  // sweep writes zero instead of the scaled word
        logic       sweep_clr;   // restart the sweep at address zero
        logic       out_load;    // capture a result
        logic [1:0] status;
    } lss_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       active;
        logic       idx_ok;
        logic       n_zero;
        logic       need_fetch;
        logic       sweep_end_n;
        logic       sweep_end_all;
        logic       out_free;
    } lss_stat_t;

endpackage

// ===== rtl/lss_ram.sv =====
`timescale 1ns / 1ps

module lss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/lss_ctrl.sv =====
`timescale 1ns / 1ps

module lss_ctrl
    import lss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  lss_stat_t stat,
    output lss_cmd_t  cmd
);

    localparam logic [2:0] CLEAR_S  = 3'd0;
    localparam logic [2:0] IDLE_S   = 3'd1;
    localparam logic [2:0] DECODE_S = 3'd2;
    localparam logic [2:0] WRITE_S  = 3'd3;
    localparam logic [2:0] SWEEP_S  = 3'd4;
    localparam logic [2:0] LOAD_S   = 3'd5;
    localparam logic [2:0] RESP_S   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       zero_reg, zero_next;

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        zero_next   = zero_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        s_tready    = 1'b0;

        unique case (state_reg)
            CLEAR_S: begin
                cmd.wr_sweep   = 1'b1;
                cmd.sweep_zero = 1'b1;
                if (stat.sweep_end_all) begin
                    state_next = IDLE_S;
                end
            end
            IDLE_S: begin
                s_tready    = 1'b1;
                cmd.in_load = s_tvalid;
                if (s_tvalid) begin
                    state_next = DECODE_S;
                end
            end
            DECODE_S: begin
                status_next = ST_OK;
                state_next  = RESP_S;
                if (stat.cmd == CMD_TICK) begin
                    cmd.tick_exec = 1'b1;
                    if (stat.need_fetch) begin
                        state_next = LOAD_S;
                    end
                end else if (stat.active || stat.cmd > CMD_TICK) begin
                    status_next = ST_IGNORED;
                end else begin
                    case (stat.cmd)
                        CMD_SET: begin
                            if (stat.idx_ok) begin
                                state_next = WRITE_S;
                            end else begin
                                status_next = ST_IGNORED;
                            end
                        end
                        CMD_FILL, CMD_CLEAR: begin
                            zero_next     = (stat.cmd == CMD_CLEAR);
                            cmd.sweep_clr = 1'b1;
                            if (!stat.n_zero) begin
                                state_next = SWEEP_S;
                            end
                        end
                        default: begin
                            if (stat.n_zero) begin
                                status_next = ST_EMPTY;
                            end else begin
                                cmd.show_start = 1'b1;
                                state_next     = LOAD_S;
                            end
                        end
                    endcase
                end
            end
            WRITE_S: begin
                cmd.wr_set = 1'b1;
                state_next = RESP_S;
            end
            SWEEP_S: begin
                cmd.wr_sweep   = 1'b1;
                cmd.sweep_zero = zero_reg;
                if (stat.sweep_end_n) begin
                    state_next = RESP_S;
                end
            end
            LOAD_S: begin
                cmd.load_word = 1'b1;
                state_next    = RESP_S;
            end
            RESP_S: begin
                // Hold here until the result slot frees up
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    s_tready     = 1'b1;
                    cmd.in_load  = s_tvalid;
                    state_next   = s_tvalid ? DECODE_S : IDLE_S;
                end
            end
            default: begin
                state_next = IDLE_S;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= CLEAR_S;
            status_reg <= ST_OK;
            zero_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            zero_reg   <= zero_next;
        end
    end

endmodule

// ===== rtl/lss_datapath.sv =====
`timescale 1ns / 1ps

module lss_datapath
    import lss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input transaction fields
    input  logic [2:0]  in_command,
    input  logic [8:0]  in_pixel_index,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    input  logic [7:0]  in_brightness,
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // result
    input  logic        m_tready,
    output logic        out_valid,
    output logic        out_line_level,
    output logic        out_sending,
    output logic [1:0]  out_status,
    // control
    input  lss_cmd_t    cmd,
    output lss_stat_t   stat
);

    // Configuration
    logic [9:0]  led_count_reg;
    logic [7:0]  zero_high_reg, zero_low_reg, one_high_reg, one_low_reg;
    logic [15:0] latch_gap_reg;

    // Captured transaction
    logic [2:0]  cmd_reg;
    logic [8:0]  idx_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, bright_reg;

    // Scaling products
    logic [15:0] prod_r_reg, prod_g_reg, prod_b_reg;

    // Serializer state
    logic              active_reg, active_next;
    logic [CNT_W-1:0]  pixel_reg, pixel_next;
    logic [4:0]        bit_reg, bit_next;
    logic [1:0]        phase_reg, phase_next;
    logic [15:0]       tick_reg, tick_next;
    logic [WORD_W-1:0] shift_reg, shift_next;

    // Sweep address
    logic [ADDR_W-1:0] sweep_reg;

    // Result register
    logic       out_valid_reg;
    logic       line_reg, sending_reg;
    logic [1:0] status_reg;

    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  pixel_inc;
    logic [4:0]        bit_inc;
    logic              bit_wrap;
    logic [CNT_W-1:0]  pixel_adv;
    logic              frame_end;
    logic              tick_live;
    logic              tick_done;
    logic [WORD_W-1:0] scaled_word;
    logic [WORD_W-1:0] ram_rd_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic              ram_wr_en;

    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] sum;
        logic [8:0]  q;
        logic [16:0] rem;
        sum = {1'b0, p} + {9'b0, p[15:8]};
        q   = sum[16:8];
        rem = {1'b0, p} - ({q, 8'b0} - {8'b0, q});
        // estimate is at most one below the true quotient
        if (rem >= 17'd255) begin
            q = q + 9'd1;
        end
        return q[7:0];
    endfunction

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // Clamp the LED count to the store size
    always_comb begin
        if (32'(led_count_reg) > MAX_PIXELS) begin
            n_cnt = CNT_W'(MAX_PIXELS);
        end else begin
            n_cnt = CNT_W'(led_count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg <= RST_LED_COUNT;
            zero_high_reg <= RST_ZERO_HIGH;
            zero_low_reg  <= RST_ZERO_LOW;
            one_high_reg  <= RST_ONE_HIGH;
            one_low_reg   <= RST_ONE_LOW;
            latch_gap_reg <= RST_LATCH_GAP;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LED_COUNT: led_count_reg <= cfg_data[9:0];
                CFG_ZERO_HIGH: zero_high_reg <= cfg_data[7:0];
                CFG_ZERO_LOW:  zero_low_reg  <= cfg_data[7:0];
                CFG_ONE_HIGH:  one_high_reg  <= cfg_data[7:0];
                CFG_ONE_LOW:   one_low_reg   <= cfg_data[7:0];
                CFG_LATCH_GAP: latch_gap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            idx_reg    <= in_pixel_index;
            red_reg    <= in_red;
            green_reg  <= in_green;
            blue_reg   <= in_blue;
            bright_reg <= in_brightness;
        end
        prod_r_reg <= red_reg * bright_reg;
        prod_g_reg <= green_reg * bright_reg;
        prod_b_reg <= blue_reg * bright_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg <= CMD_TICK;
        end else if (cmd.in_load) begin
            cmd_reg <= in_command;
        end
    end

    assign scaled_word = {div255(prod_g_reg), div255(prod_r_reg), div255(prod_b_reg)};

    // Tick arithmetic
    assign pixel_inc = pixel_reg + CNT_W'(1);
    assign bit_inc   = bit_reg + 5'd1;
    assign bit_wrap  = (bit_inc >= 5'd24);
    assign pixel_adv = bit_wrap ? pixel_inc : pixel_reg;
    assign frame_end = (pixel_adv >= n_cnt);
    assign tick_live = active_reg && (tick_reg != 16'd0);
    assign tick_done = tick_live && (tick_reg == 16'd1);

    always_comb begin
        active_next = active_reg;
        pixel_next  = pixel_reg;
        bit_next    = bit_reg;
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        shift_next  = shift_reg;

        if (cmd.tick_exec && tick_live) begin
            tick_next = tick_reg - 16'd1;
            if (tick_done) begin
                case (phase_reg)
                    PH_HIGH: begin
                        phase_next = PH_LOW;
                        tick_next  = at_least_one({8'd0,
                            shift_reg[WORD_W-1] ? one_low_reg : zero_low_reg});
                    end
                    PH_LOW: begin
                        shift_next = {shift_reg[WORD_W-2:0], 1'b0};
                        bit_next   = bit_wrap ? 5'd0 : bit_inc;
                        pixel_next = pixel_adv;
                        if (frame_end) begin
                            phase_next = PH_GAP;
                            tick_next  = at_least_one(latch_gap_reg);
                        end else if (!bit_wrap) begin
                            phase_next = PH_HIGH;
                            tick_next  = at_least_one({8'd0,
                                shift_reg[WORD_W-2] ? one_high_reg : zero_high_reg});
                        end else begin
                            // next pixel word arrives from the store; hold phase
                            tick_next = tick_reg;
                        end
                    end
                    PH_GAP: begin
                        phase_next  = PH_IDLE;
                        active_next = 1'b0;
                        tick_next   = 16'd0;
                    end
                    default: ;
                endcase
            end
        end

        if (cmd.show_start) begin
            active_next = 1'b1;
            pixel_next  = '0;
            bit_next    = 5'd0;
        end

        if (cmd.load_word) begin
            shift_next = ram_rd_data;
            phase_next = PH_HIGH;
            tick_next  = at_least_one({8'd0,
                ram_rd_data[WORD_W-1] ? one_high_reg : zero_high_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            pixel_reg  <= '0;
            bit_reg    <= 5'd0;
            phase_reg  <= PH_IDLE;
            tick_reg   <= 16'd0;
            shift_reg  <= '0;
        end else begin
            active_reg <= active_next;
            pixel_reg  <= pixel_next;
            bit_reg    <= bit_next;
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            shift_reg  <= shift_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else if (cmd.sweep_clr) begin
            sweep_reg <= '0;
        end else if (cmd.wr_sweep) begin
            sweep_reg <= sweep_reg + ADDR_W'(1);
        end
    end

    // Pixel store
    assign ram_rd_addr = (cmd_reg == CMD_SHOW) ? '0 : pixel_inc[ADDR_W-1:0];
    assign ram_wr_en   = cmd.wr_set || cmd.wr_sweep;
    assign ram_wr_addr = cmd.wr_sweep ? sweep_reg : ADDR_W'(idx_reg);
    assign ram_wr_data = (cmd.wr_sweep && cmd.sweep_zero) ? '0 : scaled_word;

    lss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            line_reg    <= active_reg && (phase_reg == PH_HIGH);
            sending_reg <= active_reg;
            status_reg  <= cmd.status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_line_level = line_reg;
    assign out_sending    = sending_reg;
    assign out_status     = status_reg;

    assign stat.cmd           = cmd_reg;
    assign stat.active        = active_reg;
    assign stat.idx_ok        = ({23'd0, idx_reg} < 32'(n_cnt));
    assign stat.n_zero        = (n_cnt == '0);
    assign stat.need_fetch    = tick_done && (phase_reg == PH_LOW) && bit_wrap && !frame_end;
    assign stat.sweep_end_n   = (32'(sweep_reg) + 32'd1 == 32'(n_cnt));
    assign stat.sweep_end_all = (32'(sweep_reg) == MAX_PIXELS - 1);
    assign stat.out_free      = !out_valid_reg || m_tready;

endmodule

// ===== rtl/led_strip_frame_serializer.sv =====
`timescale 1ns / 1ps

// A tick or a rejected command goes from the decode state straight to the result state;
// set, show and a tick that starts a new pixel pass a write or load state; fill and clear
// sweep the n LEDs in use. Transactions are taken only in idle or as a result is loaded.
// Pixel words are fetched from the single-port-read store the cycle after the read address.
// Reset (aresetn low, synchronous) clears control, configuration and serializer state, then
// zeroes the whole pixel store with s_tready low; configuration writes are taken throughout.
module led_strip_frame_serializer
    import lss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pixel_index[8:0], red[16:9], green[24:17],
                                   // blue[32:25], brightness[40:33], zero pad
    input  logic [2:0]  s_tuser,   // command[2:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // line_level[0], sending[1], status[3:2], zero pad
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    lss_cmd_t   cmd;
    lss_stat_t  stat;
    logic       line_level;
    logic       sending;
    logic [1:0] status;

    assign cfg_ready = 1'b1;

    lss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lss_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_command     (s_tuser),
        .in_pixel_index (s_tdata[8:0]),
        .in_red         (s_tdata[16:9]),
        .in_green       (s_tdata[24:17]),
        .in_blue        (s_tdata[32:25]),
        .in_brightness  (s_tdata[40:33]),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_tready       (m_tready),
        .out_valid      (m_tvalid),
        .out_line_level (line_level),
        .out_sending    (sending),
        .out_status     (status),
        .cmd            (cmd),
        .stat           (stat)
    );

    assign m_tdata = {4'd0, status, sending, line_level};

endmodule

// ===== sim/led_strip_frame_serializer_tb.sv =====
`timescale 1ns / 1ps

module led_strip_frame_serializer_tb;
    import lss_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int ITEM_TARGET    = 620;
    localparam int ITEM_LIMIT     = 660;
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0] cmd;
        logic [8:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] bright;
    } strip_cmd_t;

    typedef struct packed {
        logic       line;
        logic       sending;
        logic [1:0] status;
    } line_state_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    led_strip_frame_serializer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Strip state as the block should hold it
    logic [23:0] pix_store [MAX_PIXELS];
    logic        tx_on;
    logic [9:0]  tx_pix;
    logic [4:0]  tx_bit;
    logic [1:0]  tx_phase;
    logic [15:0] tx_ticks;
    logic [23:0] tx_word;
    logic [9:0]  cfg_leds;
    logic [7:0]  cfg_zh, cfg_zl, cfg_oh, cfg_ol;
    logic [15:0] cfg_gap;

    strip_cmd_t  strip_cmds [$];
    line_state_t line_states_due [$];
    strip_cmd_t  drv_cmd;
    line_state_t drv_state;
    int          send_gap;
    int          ready_wait;
    bit          idle_mode = 1'b1;
    int          items_sent;
    int          mismatch_count;
    int          quiet_cycles;

    function automatic logic [9:0] leds_in_use();
        return (cfg_leds > MAX_PIXELS) ? 10'(MAX_PIXELS) : cfg_leds;
    endfunction

    function automatic logic [15:0] min_one(input logic [15:0] v);
        return (v == 0) ? 16'd1 : v;
    endfunction

    function automatic logic [7:0] dim(input logic [7:0] c, input logic [7:0] br);
        int p;
        p = int'(c) * int'(br);
        return 8'(p / 255);
    endfunction

    task automatic start_high();
        tx_phase = PH_HIGH;
        tx_ticks = min_one(tx_word[23] ? 16'(cfg_oh) : 16'(cfg_zh));
    endtask

    task automatic advance_phase();
        if (tx_phase == PH_HIGH) begin
            tx_phase = PH_LOW;
            tx_ticks = min_one(tx_word[23] ? 16'(cfg_ol) : 16'(cfg_zl));
        end else if (tx_phase == PH_LOW) begin
            tx_word = tx_word << 1;
            tx_bit  = tx_bit + 1'b1;
            if (tx_bit >= 24) begin
                tx_bit = '0;
                tx_pix = tx_pix + 1'b1;
            end
            // led_count may have shrunk under the frame: close it with the gap
            if (tx_pix >= leds_in_use() || tx_pix >= MAX_PIXELS) begin
                tx_phase = PH_GAP;
                tx_ticks = min_one(cfg_gap);
            end else begin
                if (tx_bit == 0)
                    tx_word = pix_store[tx_pix];
                start_high();
            end
        end else if (tx_phase == PH_GAP) begin
            tx_phase = PH_IDLE;
            tx_on    = 1'b0;
            tx_ticks = '0;
        end
    endtask

    task automatic predict_line_state(input strip_cmd_t c, output line_state_t r);
        logic [9:0]  n;
        logic [1:0]  st;
        logic [23:0] word;
        n    = leds_in_use();
        st   = ST_OK;
        word = {dim(c.green, c.bright), dim(c.red, c.bright), dim(c.blue, c.bright)};
        if (c.cmd == CMD_TICK) begin
            if (tx_on && tx_ticks != 0) begin
                tx_ticks = tx_ticks - 1'b1;
                if (tx_ticks == 0)
                    advance_phase();
            end
        end else if (tx_on || c.cmd > CMD_TICK) begin
            st = ST_IGNORED;
        end else begin
            case (c.cmd)
                CMD_SET: begin
                    if (c.idx < n)
                        pix_store[c.idx] = word;
                    else
                        st = ST_IGNORED;
                end
                CMD_FILL: begin
                    for (int i = 0; i < n; i++)
                        pix_store[i] = word;
                end
                CMD_CLEAR: begin
                    for (int i = 0; i < n; i++)
                        pix_store[i] = '0;
                end
                default: begin
                    if (n == 0) begin
                        st = ST_EMPTY;
                    end else begin
                        tx_on   = 1'b1;
                        tx_pix  = '0;
                        tx_bit  = '0;
                        tx_word = pix_store[0];
                        start_high();
                    end
                end
            endcase
        end
        r.line    = tx_on && tx_phase == PH_HIGH;
        r.sending = tx_on;
        r.status  = st;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_line_state(drv_cmd, drv_state);
                line_states_due.push_back(drv_state);
            end
            if (s_tvalid && !s_tready) begin
                // hold the transaction until taken
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (strip_cmds.size() > 0) begin
                drv_cmd = strip_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_cmd.cmd;
                s_tdata  <= {7'd0, drv_cmd.bright, drv_cmd.blue, drv_cmd.green,
                             drv_cmd.red, drv_cmd.idx};
                send_gap <= idle_mode ? int'($urandom_range(0, 5)) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        line_state_t want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (line_states_due.size() == 0) begin
                    report_mismatch("unexpected result, status", m_tdata[3:2], -1);
                end else begin
                    want = line_states_due.pop_front();
                    if (m_tdata[0] !== want.line)
                        report_mismatch("line_level", m_tdata[0], want.line);
                    if (m_tdata[1] !== want.sending)
                        report_mismatch("sending", m_tdata[1], want.sending);
                    if (m_tdata[3:2] !== want.status)
                        report_mismatch("status", m_tdata[3:2], want.status);
                end
                ready_wait = idle_mode ? int'($urandom_range(0, 5)) : 0;
            end else if (ready_wait > 0) begin
                ready_wait = ready_wait - 1;
            end
            m_tready <= (ready_wait == 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("led_strip_frame_serializer test failed");
                $finish;
            end
        end else begin
            quiet_cycles <= 0;
        end
    end

    function automatic strip_cmd_t random_cmd(input logic [2:0] c);
        strip_cmd_t r;
        r.cmd    = c;
        r.idx    = 9'($urandom_range(0, 511));
        r.red    = 8'($urandom_range(0, 255));
        r.green  = 8'($urandom_range(0, 255));
        r.blue   = 8'($urandom_range(0, 255));
        r.bright = 8'($urandom_range(0, 255));
        return r;
    endfunction

    task automatic push_cmd(input strip_cmd_t c);
        strip_cmds.push_back(c);
        items_sent++;
    endtask

    task automatic push_color(input logic [2:0] c, input logic [8:0] idx, input logic [7:0] red,
                              input logic [7:0] green, input logic [7:0] blue,
                              input logic [7:0] bright);
        push_cmd('{c, idx, red, green, blue, bright});
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (strip_cmds.size() != 0 || s_tvalid || line_states_due.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LED_COUNT: cfg_leds = val[9:0];
            CFG_ZERO_HIGH: cfg_zh   = val[7:0];
            CFG_ZERO_LOW:  cfg_zl   = val[7:0];
            CFG_ONE_HIGH:  cfg_oh   = val[7:0];
            CFG_ONE_LOW:   cfg_ol   = val[7:0];
            CFG_LATCH_GAP: cfg_gap  = val;
            default: ;
        endcase
    endtask

    task automatic write_timing(input logic [9:0] leds, input logic [7:0] zh, input logic [7:0] zl,
                                input logic [7:0] oh, input logic [7:0] ol,
                                input logic [15:0] gap);
        // let any result-free work in the block run out first
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(CFG_LED_COUNT, 16'(leds));
        write_reg(CFG_ZERO_HIGH, 16'(zh));
        write_reg(CFG_ZERO_LOW, 16'(zl));
        write_reg(CFG_ONE_HIGH, 16'(oh));
        write_reg(CFG_ONE_LOW, 16'(ol));
        write_reg(CFG_LATCH_GAP, gap);
        @(negedge aclk);
    endtask

    task automatic random_timing(output bit long_frame);
        logic [9:0]  leds;
        logic [7:0]  len [4];
        logic [15:0] gap;
        int          r;
        r = $urandom_range(0, 15);
        if (r == 0)
            leds = '0;
        else if (r == 1)
            leds = 10'($urandom_range(0, 1023));
        else if (r == 2)
            leds = 10'(MAX_PIXELS);
        else
            leds = 10'($urandom_range(1, 2));
        long_frame = (leds > 8);
        for (int i = 0; i < 4; i++) begin
            r = $urandom_range(0, 11);
            if (r == 0)
                len[i] = '0;
            else if (r == 1)
                len[i] = 8'($urandom_range(0, 16));
            else
                len[i] = 8'($urandom_range(1, 2));
            if (len[i] > 8)
                long_frame = 1'b1;
        end
        r = $urandom_range(0, 11);
        if (r == 0)
            gap = '0;
        else if (r == 1)
            gap = 16'($urandom_range(0, 100));
        else
            gap = 16'($urandom_range(1, 8));
        if (gap > 64)
            long_frame = 1'b1;
        write_timing(leds, len[0], len[1], len[2], len[3], gap);
    endtask

    // Tick the frame along; a stray command now and then must be refused while busy.
    // max_chunks of zero runs until the line is idle or the item budget is spent.
    task automatic run_frame(input int max_chunks, input int chunk_len);
        int         chunks;
        strip_cmd_t c;
        chunks = 0;
        while (tx_on && (max_chunks == 0 ? items_sent < ITEM_LIMIT : chunks < max_chunks)) begin
            repeat (chunk_len) begin
                if ($urandom_range(0, 11) == 0)
                    c = random_cmd(3'($urandom_range(0, 7)));
                else
                    c = random_cmd(CMD_TICK);
                push_cmd(c);
            end
            wait_drained();
            chunks++;
        end
    endtask

    initial begin
        bit         long_frame;
        int         r;
        logic [9:0] n;
        strip_cmd_t c;

        for (int i = 0; i < MAX_PIXELS; i++)
            pix_store[i] = '0;
        tx_on    = 1'b0;
        tx_pix   = '0;
        tx_bit   = '0;
        tx_phase = PH_IDLE;
        tx_ticks = '0;
        tx_word  = '0;
        cfg_leds = RST_LED_COUNT;
        cfg_zh   = RST_ZERO_HIGH;
        cfg_zl   = RST_ZERO_LOW;
        cfg_oh   = RST_ONE_HIGH;
        cfg_ol   = RST_ONE_LOW;
        cfg_gap  = RST_LATCH_GAP;
        items_sent     = 0;
        mismatch_count = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // No LEDs in use after reset
        push_cmd(random_cmd(CMD_SHOW));
        push_color(CMD_SET, 9'd0, 8'd10, 8'd20, 8'd30, 8'd255);
        push_cmd(random_cmd(CMD_TICK));
        push_cmd(random_cmd(CMD_UNUSED_LO));
        push_cmd(random_cmd(CMD_UNUSED_HI));
        push_cmd(random_cmd(CMD_FILL));
        push_cmd(random_cmd(CMD_CLEAR));
        wait_drained();

        write_timing(10'd2, 8'd1, 8'd2, 8'd2, 8'd1, 16'd4);
        push_color(CMD_FILL, 9'd0, 8'd200, 8'd100, 8'd50, 8'd128);
        push_cmd(random_cmd(CMD_CLEAR));
        push_color(CMD_SET, 9'd0, 8'd255, 8'd255, 8'd255, 8'd255);
        push_color(CMD_SET, 9'd1, 8'h5a, 8'ha5, 8'h3c, 8'd255);
        push_color(CMD_SET, 9'd2, 8'd255, 8'd255, 8'd255, 8'd0);
        push_color(CMD_SET, 9'd3, 8'd1, 8'd2, 8'd3, 8'd255);
        push_color(CMD_SET, 9'd511, 8'd1, 8'd2, 8'd3, 8'd255);
        push_cmd(random_cmd(CMD_SHOW));
        // refused while the frame is on the line
        push_cmd(random_cmd(CMD_SET));
        push_cmd(random_cmd(CMD_FILL));
        push_cmd(random_cmd(CMD_CLEAR));
        push_cmd(random_cmd(CMD_SHOW));
        push_cmd(random_cmd(CMD_UNUSED_LO));
        wait_drained();
        run_frame(0, 32);

        // Lengths of zero, led_count beyond the store: fill the whole store, start a frame
        write_timing(10'd1023, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        push_cmd(random_cmd(CMD_FILL));
        push_color(CMD_SET, 9'd511, 8'd0, 8'd0, 8'd0, 8'd255);
        push_cmd(random_cmd(CMD_SET));
        push_cmd(random_cmd(CMD_SHOW));
        wait_drained();
        run_frame(2, 50);

        // Shrink led_count under the running frame
        write_timing(10'd1, 8'd2, 8'd2, 8'd2, 8'd2, 16'd3);
        run_frame(0, 16);

        while (items_sent < ITEM_TARGET) begin
            idle_mode = ($urandom_range(0, 3) != 0);
            random_timing(long_frame);
            n = leds_in_use();
            repeat ($urandom_range(2, 8)) begin
                r = $urandom_range(0, 9);
                if (r <= 4) begin
                    c = random_cmd(CMD_SET);
                    if (n > 0)
                        c.idx = 9'($urandom_range(0, n - 1));
                end else if (r == 5) begin
                    c = random_cmd(CMD_SET);
                end else if (r == 6) begin
                    c = random_cmd(CMD_FILL);
                end else if (r == 7) begin
                    c = random_cmd(CMD_CLEAR);
                end else if (r == 8) begin
                    c = random_cmd(CMD_TICK);
                end else begin
                    c = random_cmd(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)));
                end
                push_cmd(c);
            end
            if ($urandom_range(0, 6) != 0)
                push_cmd(random_cmd(CMD_SHOW));
            else
                push_cmd(random_cmd(3'($urandom_range(0, 7))));
            wait_drained();
            // sometimes leave the frame running into the next settings
            run_frame((long_frame || $urandom_range(0, 7) == 0) ? 1 : 0,
                      $urandom_range(16, 64));
        end

        // Longest pulses and gap; the frame is left on the line
        write_timing(10'd1, 8'd255, 8'd255, 8'd255, 8'd255, 16'd65535);
        push_cmd(random_cmd(CMD_SHOW));
        wait_drained();
        run_frame(1, 40);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (line_states_due.size() != 0)
            report_mismatch("results never delivered", 0, line_states_due.size());
        if (mismatch_count == 0)
            $display("led_strip_frame_serializer test passed");
        else
            $display("led_strip_frame_serializer test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lss_pkg.sv
rtl/lss_ram.sv
rtl/lss_ctrl.sv
rtl/lss_datapath.sv
rtl/led_strip_frame_serializer.sv
sim/led_strip_frame_serializer_tb.sv
